### hw/rtl/ps2_frame_receiver_fifo_macros.svh
// ----------------------------------------------------------------------------
// PS/2 receiver assertion macros
// Shared concurrent assertion forms for the receiver block.
// ----------------------------------------------------------------------------
`ifndef PS2_FRAME_RECEIVER_FIFO_MACROS_SVH
`define PS2_FRAME_RECEIVER_FIFO_MACROS_SVH

// same-cycle implication
`define PS2RX_ASSERT_IMPL(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("ps2rx: same-cycle check failed");

// next-cycle implication
`define PS2RX_ASSERT_NEXT(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("ps2rx: next-cycle check failed");

`endif

### hw/rtl/ps2rx_pkg.sv
// ----------------------------------------------------------------------------
// PS/2 receiver package
// Types and constants shared by the receiver files.
// ----------------------------------------------------------------------------
package ps2rx_pkg;

    localparam int QUEUE_SLOTS_DEF = 64;

    localparam int TIME_W    = 32;
    localparam int TIMEOUT_W = 16;
    localparam int CODE_W    = 8;
    localparam int IDX_W     = 4;

    localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET  = 16'd250;
    localparam logic [IDX_W-1:0]     FRAME_EDGES    = 4'd11;
    localparam logic [IDX_W-1:0]     FIRST_DATA_EDGE = 4'd1;
    localparam logic [IDX_W-1:0]     LAST_DATA_EDGE = 4'd8;   // data bit 7

    localparam logic OP_EDGE = 1'b0;
    localparam logic OP_READ = 1'b1;

    typedef struct packed {
        logic              operation;
        logic              data_bit;
        logic [TIME_W-1:0] time_now;
    } in_item_t;

    typedef struct packed {
        logic [CODE_W-1:0] scan_code;
        logic              queue_empty;
    } out_item_t;

    typedef struct packed {
        logic              valid;
        logic [CODE_W-1:0] code;
    } push_t;

endpackage

### hw/rtl/ps2rx_chan_if.sv
// ----------------------------------------------------------------------------
// PS/2 receiver channel
// Valid/ready channel carrying one payload item per handshake.
// ----------------------------------------------------------------------------
interface ps2rx_chan_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

### hw/rtl/ps2rx_ram.sv
// ----------------------------------------------------------------------------
// PS/2 receiver RAM
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module ps2rx_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### hw/rtl/ps2rx_frame.sv
// ----------------------------------------------------------------------------
// PS/2 frame assembler
// Counts edges of one frame, shifts in data bits, flags a completed byte.
// ----------------------------------------------------------------------------
module ps2rx_frame (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                edge_en,
    input  logic                                data_bit,
    input  logic [ps2rx_pkg::TIME_W-1:0]        time_now,
    input  logic [ps2rx_pkg::TIMEOUT_W-1:0]     timeout_ticks,
    output ps2rx_pkg::push_t                    push
);

    logic [ps2rx_pkg::IDX_W-1:0]  bit_index_reg;
    logic [ps2rx_pkg::CODE_W-1:0] shift_byte_reg;
    logic [ps2rx_pkg::TIME_W-1:0] last_edge_time_reg;

    logic [ps2rx_pkg::TIME_W-1:0] gap;
    logic                         timed_out;
    logic [ps2rx_pkg::IDX_W-1:0]  base_idx;
    logic [ps2rx_pkg::CODE_W-1:0] base_byte;
    logic [2:0]                   pos;
    logic [ps2rx_pkg::CODE_W-1:0] shift_byte_next;
    logic [ps2rx_pkg::IDX_W-1:0]  bit_index_next;
    logic                         done;

    // wrap-around gap, unsigned compare
    assign gap       = time_now - last_edge_time_reg;
    assign timed_out = gap > {{(ps2rx_pkg::TIME_W-ps2rx_pkg::TIMEOUT_W){1'b0}}, timeout_ticks};
    assign base_idx  = timed_out ? '0 : bit_index_reg;
    assign base_byte = timed_out ? '0 : shift_byte_reg;
    assign pos       = 3'(base_idx - ps2rx_pkg::FIRST_DATA_EDGE);

    always_comb
    begin
        shift_byte_next = base_byte;
        if (base_idx >= ps2rx_pkg::FIRST_DATA_EDGE && base_idx <= ps2rx_pkg::LAST_DATA_EDGE)
        begin
            shift_byte_next[pos] = data_bit;
        end
    end

    assign bit_index_next = base_idx + 4'd1;
    assign done           = bit_index_next == ps2rx_pkg::FRAME_EDGES;

    assign push.valid = edge_en && done;
    assign push.code  = shift_byte_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bit_index_reg      <= '0;
            shift_byte_reg     <= '0;
            last_edge_time_reg <= '0;
        end
        else if (edge_en)
        begin
            last_edge_time_reg <= time_now;
            if (done)
            begin
                bit_index_reg  <= '0;
                shift_byte_reg <= '0;
            end
            else
            begin
                bit_index_reg  <= bit_index_next;
                shift_byte_reg <= shift_byte_next;
            end
        end
    end

endmodule

### hw/rtl/ps2_frame_receiver_fifo.sv
// ----------------------------------------------------------------------------
// PS/2 frame receiver with byte queue
// Assembles PS/2 frames from sampled clock edges and queues received bytes.
// ----------------------------------------------------------------------------
// Usage:
//   item   : valid/ready input. operation = edge carries one falling clock
//            edge (data_bit, time_now); operation = read pops one byte.
//   result : valid/ready output, one item per read: scan_code and
//            queue_empty (scan_code is 0 when the queue was empty).
//   cfg    : valid/ready write of timeout_ticks (16 bits); always ready.
//            Write only while the block is idle.
// Path: a read passes the input stage, the RAM read stage s1 and the
//   output register before result.valid rises. Edges produce no result.
// Throughput: one item per cycle while no read waits for room in s1; set by
//   the frame update and the one write / one read port of the queue RAM.
// Reset: frame counter, shift register, last edge time and both queue
//   pointers clear; timeout_ticks returns to 250. Queue RAM is not cleared
//   and needs no clearing pass; the block is ready right after reset.
// Stall: while result.ready is low the output register holds its item;
//   edges keep flowing, and one more read can sit in each inner stage
//   before item.ready drops.
// ----------------------------------------------------------------------------
`include "ps2_frame_receiver_fifo_macros.svh"

module ps2_frame_receiver_fifo #(
    parameter int QUEUE_SLOTS = ps2rx_pkg::QUEUE_SLOTS_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    ps2rx_chan_if.sink   item,
    ps2rx_chan_if.source result,
    ps2rx_chan_if.sink   cfg
);

    localparam int PTR_W = $clog2(QUEUE_SLOTS);
    localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(QUEUE_SLOTS - 1);

    // configuration
    logic [ps2rx_pkg::TIMEOUT_W-1:0] timeout_ticks_reg;

    // input stage
    logic                 s0_valid_reg;
    ps2rx_pkg::in_item_t  s0_item_reg;
    logic                 s0_fire;
    logic                 s0_edge_fire;
    logic                 s0_read_fire;

    // RAM read stage
    logic                 s1_valid_reg;
    logic                 s1_empty_reg;
    logic                 s1_free;
    logic                 s1_move;

    // output register
    logic                 out_valid_reg;
    ps2rx_pkg::out_item_t out_item_reg;

    // queue
    logic [PTR_W-1:0]     write_ptr_reg;
    logic [PTR_W-1:0]     read_ptr_reg;
    logic [PTR_W-1:0]     write_ptr_inc;
    logic [PTR_W-1:0]     read_ptr_inc;
    logic                 queue_is_empty;
    logic                 ram_we;
    logic                 ram_re;
    logic [ps2rx_pkg::CODE_W-1:0] ram_rdata;
    ps2rx_pkg::push_t     push;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_ticks_reg <= ps2rx_pkg::TIMEOUT_RESET;
        end
        else if (cfg.valid)
        begin
            timeout_ticks_reg <= cfg.data;
        end
    end

    // Handshake chain. Edges never wait; a read waits only for room in s1.
    assign s1_move      = s1_valid_reg && (!out_valid_reg || result.ready);
    assign s1_free      = !s1_valid_reg || s1_move;
    assign s0_fire      = s0_valid_reg &&
                          (s0_item_reg.operation == ps2rx_pkg::OP_EDGE || s1_free);
    assign s0_edge_fire = s0_fire && s0_item_reg.operation == ps2rx_pkg::OP_EDGE;
    assign s0_read_fire = s0_fire && s0_item_reg.operation == ps2rx_pkg::OP_READ;
    assign item.ready   = !s0_valid_reg || s0_fire;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg <= 1'b0;
        end
        else if (item.ready)
        begin
            s0_valid_reg <= item.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item.valid && item.ready)
        begin
            s0_item_reg <= item.data;
        end
    end

    // frame assembly
    ps2rx_frame u_frame (
        .clk           (clk),
        .rst_n         (rst_n),
        .edge_en       (s0_edge_fire),
        .data_bit      (s0_item_reg.data_bit),
        .time_now      (s0_item_reg.time_now),
        .timeout_ticks (timeout_ticks_reg),
        .push          (push)
    );

    // Ring pointers: advance first, then access the new slot. One slot
    // always stays empty, so full is "next write slot == read slot".
    assign write_ptr_inc  = (write_ptr_reg == LAST_SLOT) ? '0 : write_ptr_reg + 1'b1;
    assign read_ptr_inc   = (read_ptr_reg == LAST_SLOT) ? '0 : read_ptr_reg + 1'b1;
    assign queue_is_empty = write_ptr_reg == read_ptr_reg;
    assign ram_we         = push.valid && (write_ptr_inc != read_ptr_reg);
    assign ram_re         = s0_read_fire && !queue_is_empty;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            write_ptr_reg <= '0;
            read_ptr_reg  <= '0;
        end
        else
        begin
            if (ram_we)
            begin
                write_ptr_reg <= write_ptr_inc;
            end
            if (ram_re)
            begin
                read_ptr_reg <= read_ptr_inc;
            end
        end
    end

    ps2rx_ram #(
        .WIDTH (ps2rx_pkg::CODE_W),
        .DEPTH (QUEUE_SLOTS)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (write_ptr_inc),
        .wdata (push.code),
        .re    (ram_re),
        .raddr (read_ptr_inc),
        .rdata (ram_rdata)
    );

    // s1: waits for the registered RAM read
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (s0_read_fire)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (s1_move)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s0_read_fire)
        begin
            s1_empty_reg <= queue_is_empty;
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_move)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_move)
        begin
            out_item_reg.scan_code   <= s1_empty_reg ? '0 : ram_rdata;
            out_item_reg.queue_empty <= s1_empty_reg;
        end
    end

    assign result.valid = out_valid_reg;
    assign result.data  = out_item_reg;

    // checks
    `PS2RX_ASSERT_IMPL(a_no_push_pop_clash, clk, rst_n, ram_we, !ram_re)
    `PS2RX_ASSERT_IMPL(a_push_not_full, clk, rst_n, ram_we, write_ptr_inc != read_ptr_reg)
    `PS2RX_ASSERT_NEXT(a_empty_read_flagged, clk, rst_n, s0_read_fire && queue_is_empty, s1_valid_reg && s1_empty_reg)
    `PS2RX_ASSERT_NEXT(a_pop_leaves_s1, clk, rst_n, ram_re, s1_valid_reg && !s1_empty_reg)

endmodule
